// ===== design/first_fit_free_list_allocator_macros.svh =====
// ---------------------------------------------------------------------------
// Allocator assertion macros
// Shared assertion forms for the allocator checker.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FFA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator check failed");
`define FFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator check failed");
`endif

// ===== design/ffa_pkg.sv =====
// ---------------------------------------------------------------------------
// Allocator package
// Types, constants and controller interface of the free-list allocator.
// ---------------------------------------------------------------------------
package ffa_pkg;
  localparam int unsigned ArenaGranules = 4096;
  localparam int unsigned GW = $clog2(ArenaGranules);
  localparam int unsigned LW = GW + 1;
  localparam int unsigned HW = GW + 2;
  localparam logic [LW-1:0] NilLink = LW'(ArenaGranules);

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_NOFIT = 2'd1, ST_NULL = 2'd2, ST_DOUBLE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_AREAD, S_ACHK, S_AUNL, S_ASPL, S_FREAD, S_FCHK, S_DONE
  } state_t;

  typedef struct packed {
    logic init_step;
    logic load;
    logic rd_walk;
    logic rd_free;
    logic advance;
    logic unlink;
    logic split;
    logic fin_alloc;
    logic fin_free;
    logic set_nofit;
    logic set_null;
    logic set_double;
    logic out_load;
  } ffa_cmd_t;

  typedef struct packed {
    logic init_done;
    logic is_alloc;
    logic free_bad;
    logic cur_nil;
    logic fits;
    logic splits;
    logic hdr_zero;
    logic hdr_free;
  } ffa_sts_t;
endpackage

// ===== design/first_fit_free_list_allocator.sv =====
// ---------------------------------------------------------------------------
// First-fit free-list allocator
// Channel   | handshake            | payload
// in_       | in_valid / in_ready  | opcode, request_bytes, release_address
// out_      | out_valid / out_ready| status, address, three totals
// After reset a clearing pass over all 4096 granules initializes the memories.
// An allocate reads and checks each free block it visits in turn, unlinks the
// first that fits, and splits it when at least two granules would remain.
// A free reads and checks the block header; a null free skips the read.
// A result held by a low out_ready holds the controller in S_DONE, where no new request is taken.
// ---------------------------------------------------------------------------
module first_fit_free_list_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [16:0] in_request_bytes,
  input  logic [15:0] in_release_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_payload_address,
  output logic [15:0] out_bytes_in_use,
  output logic [15:0] out_free_payload_bytes,
  output logic [11:0] out_free_block_count
);
  import ffa_pkg::*;

  ffa_cmd_t cmd;
  ffa_sts_t sts;

  ffa_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  ffa_dp u_dp (
    .clk, .rst_n, .cmd, .sts, .in_opcode, .in_request_bytes, .in_release_address,
    .out_status, .out_payload_address, .out_bytes_in_use,
    .out_free_payload_bytes, .out_free_block_count
  );
endmodule

// ===== design/ffa_ctrl.sv =====
// ---------------------------------------------------------------------------
// Allocator controller
// Sequences the list walk, unlink, split and free steps.
// ---------------------------------------------------------------------------
module ffa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ffa_pkg::ffa_sts_t sts,
  output ffa_pkg::ffa_cmd_t cmd
);
  import ffa_pkg::*;

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    ov_nxt    = ov_r && !out_ready;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.init_step = 1'b1;
        if (sts.init_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_AREAD;
        end
      end
      S_AREAD: begin
        if (!sts.is_alloc) begin
          if (sts.free_bad) begin
            cmd.set_null = 1'b1;
            state_nxt    = S_DONE;
          end else begin
            cmd.rd_free = 1'b1;
            state_nxt   = S_FREAD;
          end
        end else if (sts.cur_nil) begin
          cmd.set_nofit = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          cmd.rd_walk = 1'b1;
          state_nxt   = S_ACHK;
        end
      end
      S_ACHK: begin
        if (sts.fits) begin
          cmd.unlink = 1'b1;
          state_nxt  = S_AUNL;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = S_AREAD;
        end
      end
      S_AUNL: begin
        if (sts.splits) begin
          cmd.split = 1'b1;
          state_nxt = S_ASPL;
        end else begin
          cmd.fin_alloc = 1'b1;
          state_nxt     = S_DONE;
        end
      end
      S_ASPL: begin
        cmd.fin_alloc = 1'b1;
        state_nxt     = S_DONE;
      end
      S_FREAD: begin
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        if (sts.hdr_zero) begin
          cmd.set_null = 1'b1;
        end else if (sts.hdr_free) begin
          cmd.set_double = 1'b1;
        end else begin
          cmd.fin_free = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ov_r || out_ready) begin
          cmd.out_load = 1'b1;
          ov_nxt       = 1'b1;
          in_ready     = 1'b1;
          if (in_valid) begin
            cmd.load  = 1'b1;
            state_nxt = S_AREAD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end
endmodule

// ===== design/ffa_dp.sv =====
// ---------------------------------------------------------------------------
// Allocator datapath
// Header and link memories, walk pointers, totals and the result register.
// ---------------------------------------------------------------------------
module ffa_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  ffa_pkg::ffa_cmd_t cmd,
  output ffa_pkg::ffa_sts_t sts,
  input  logic              in_opcode,
  input  logic [16:0]       in_request_bytes,
  input  logic [15:0]       in_release_address,
  output logic [1:0]        out_status,
  output logic [15:0]       out_payload_address,
  output logic [15:0]       out_bytes_in_use,
  output logic [15:0]       out_free_payload_bytes,
  output logic [11:0]       out_free_block_count
);
  import ffa_pkg::*;

  logic [HW-1:0] hdr_mem [ArenaGranules];
  logic [LW-1:0] lnk_mem [ArenaGranules];

  logic [GW-1:0] init_r;
  logic          op_r;
  logic [13:0]   need_r;
  logic [15:0]   addr_r;
  logic [LW-1:0] head_r, cur_r, prev_r;
  logic [HW-1:0] hrd_r;
  logic [LW-1:0] lrd_r;
  logic [16:0]   used_r, fbytes_r;
  logic [11:0]   fblk_r;
  logic [1:0]    res_st_r;
  logic [15:0]   res_addr_r;
  logic [1:0]    ost_r;
  logic [15:0]   oaddr_r, oused_r, ofree_r;
  logic [11:0]   ocnt_r;

  logic [16:0] nbytes;
  logic [13:0] need_in;
  logic [HW-2:0] tot;
  logic [HW-1:0] want;
  logic [LW-1:0] rest;
  logic [11:0]   slot;

  assign nbytes  = (in_request_bytes == 17'd0) ? 17'd1 : in_request_bytes;
  assign need_in = 14'((nbytes + 17'd15) >> 4);
  assign tot     = hrd_r[HW-1:1];
  assign want    = HW'(need_r) + HW'(1);
  assign rest    = cur_r + LW'(want);
  assign slot    = addr_r[15:4];

  assign sts.init_done = (init_r == GW'(ArenaGranules - 1));
  assign sts.is_alloc  = !op_r;
  assign sts.free_bad  = (slot == 12'd0);
  assign sts.cur_nil   = (cur_r == NilLink);
  assign sts.fits      = (tot != '0) && (HW'(tot) - HW'(1) >= HW'(need_r));
  assign sts.splits    = HW'(tot) >= want + HW'(2);
  assign sts.hdr_zero  = (tot == '0);
  assign sts.hdr_free  = hrd_r[0];

  logic [GW-1:0] cur_g, prev_g, rest_g, fg;
  assign cur_g  = cur_r[GW-1:0];
  assign prev_g = prev_r[GW-1:0];
  assign rest_g = rest[GW-1:0];
  assign fg     = GW'(slot - 12'd1);

  always_ff @(posedge clk) begin
    if (cmd.init_step) begin
      hdr_mem[init_r] <= (init_r == '0) ? {LW'(ArenaGranules), 1'b1} : '0;
      lnk_mem[init_r] <= NilLink;
    end
    if (cmd.rd_walk) begin
      hrd_r <= hdr_mem[cur_g];
      lrd_r <= lnk_mem[cur_g];
    end
    if (cmd.rd_free) begin
      hrd_r <= hdr_mem[fg];
    end
    if (cmd.unlink) begin
      if (prev_r != NilLink) begin
        lnk_mem[prev_g] <= lrd_r;
      end
      lnk_mem[cur_g] <= NilLink;
    end
    if (cmd.split) begin
      hdr_mem[rest_g] <= {LW'(HW'(tot) - want), 1'b1};
      lnk_mem[rest_g] <= head_r;
    end
    if (cmd.fin_alloc) begin
      hdr_mem[cur_g] <= sts.splits ? {want[LW-1:0], 1'b0} : {tot, 1'b0};
    end
    if (cmd.fin_free) begin
      hdr_mem[fg] <= {tot, 1'b1};
      lnk_mem[fg] <= head_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r   <= '0;
      head_r   <= '0;
      used_r   <= '0;
      fbytes_r <= 17'((ArenaGranules - 1) * 16);
      fblk_r   <= 12'd1;
    end else begin
      if (cmd.init_step && !sts.init_done) begin
        init_r <= init_r + GW'(1);
      end
      if (cmd.unlink) begin
        if (prev_r == NilLink) begin
          head_r <= lrd_r;
        end
        fbytes_r <= fbytes_r - 17'({HW'(tot) - HW'(1), 4'd0});
      end
      if (cmd.split) begin
        head_r   <= rest;
        fbytes_r <= fbytes_r + 17'({HW'(tot) - want - HW'(1), 4'd0});
      end
      if (cmd.fin_alloc) begin
        if (!sts.splits) begin
          fblk_r <= fblk_r - 12'd1;
          used_r <= used_r + 17'({HW'(tot) - HW'(1), 4'd0});
        end else begin
          used_r <= used_r + 17'({need_r, 4'd0});
        end
      end
      if (cmd.fin_free) begin
        head_r   <= LW'(fg);
        used_r   <= used_r - 17'({HW'(tot) - HW'(1), 4'd0});
        fbytes_r <= fbytes_r + 17'({HW'(tot) - HW'(1), 4'd0});
        fblk_r   <= fblk_r + 12'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_opcode;
      need_r <= need_in;
      addr_r <= in_release_address;
      cur_r  <= head_r;
      prev_r <= NilLink;
    end
    if (cmd.advance) begin
      prev_r <= cur_r;
      cur_r  <= lrd_r;
    end
    if (cmd.fin_alloc) begin
      res_st_r   <= ST_OK;
      res_addr_r <= 16'({cur_r + LW'(1), 4'd0});
    end
    if (cmd.fin_free) begin
      res_st_r   <= ST_OK;
      res_addr_r <= '0;
    end
    if (cmd.set_nofit) begin
      res_st_r   <= ST_NOFIT;
      res_addr_r <= '0;
    end
    if (cmd.set_null) begin
      res_st_r   <= ST_NULL;
      res_addr_r <= '0;
    end
    if (cmd.set_double) begin
      res_st_r   <= ST_DOUBLE;
      res_addr_r <= '0;
    end
    if (cmd.out_load) begin
      ost_r   <= res_st_r;
      oaddr_r <= res_addr_r;
      oused_r <= used_r[15:0];
      ofree_r <= fbytes_r[15:0];
      ocnt_r  <= fblk_r;
    end
  end

  assign out_status             = ost_r;
  assign out_payload_address    = oaddr_r;
  assign out_bytes_in_use       = oused_r;
  assign out_free_payload_bytes = ofree_r;
  assign out_free_block_count   = ocnt_r;
endmodule

// ===== design/ffa_checker.sv =====
// ---------------------------------------------------------------------------
// Allocator port checker
// Port-level properties of the allocator, bound to the top level.
// ---------------------------------------------------------------------------
`include "first_fit_free_list_allocator_macros.svh"
module ffa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [15:0] out_payload_address
);
  import ffa_pkg::*;

  `FFA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `FFA_ASSERT_IMPL(a_fail_no_addr, out_valid && out_status != ST_OK, out_payload_address == '0)
  `FFA_ASSERT_IMPL(a_addr_aligned, out_valid, out_payload_address[3:0] == 4'd0)
  `FFA_ASSERT_NEXT(a_one_busy, in_valid && in_ready, !in_ready)
endmodule

bind first_fit_free_list_allocator ffa_checker u_ffa_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_status, .out_payload_address
);
